@@ hw/rtl/cbbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbbl_pkg
// Shared types and constants of the CAN button bit learner.
// ----------------------------------------------------------------------------
package cbbl_pkg;

  localparam int unsigned IdW      = 11;
  localparam int unsigned LenW     = 4;
  localparam int unsigned MaxBytes = 8;
  localparam int unsigned PayloadW = 8 * MaxBytes;
  localparam int unsigned ByteIdxW = 3;
  localparam int unsigned HitW     = 8;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CfgConfirmHits = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBindValid   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBindId      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBindByte    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBindMask    = 3'd4;

  localparam logic [HitW-1:0] ConfirmHitsReset = 8'd3;
  localparam logic [HitW-1:0] HitMax           = 8'hFF;

  // Queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [1:0] {
    OpClear    = 2'd0,
    OpBaseline = 2'd1,
    OpHunt     = 2'd2,
    OpPress    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 operation;
    logic [IdW-1:0]      frame_id;
    logic [LenW-1:0]     frame_len;
    logic [PayloadW-1:0] payload;
  } item_t;

  typedef struct packed {
    logic                hunt_done;
    logic                learned_valid;
    logic [IdW-1:0]      learned_id;
    logic [ByteIdxW-1:0] learned_byte;
    logic [7:0]          learned_mask;
    logic                is_pressed;
  } result_t;

  // A bit binding: used for the configured binding, the candidate and the
  // learned binding alike.
  typedef struct packed {
    logic                valid;
    logic [IdW-1:0]      id;
    logic [ByteIdxW-1:0] byte_sel;
    logic [7:0]          mask;
  } bind_t;

  // Classified item as it travels from front to back
  typedef struct packed {
    op_e                 op;
    logic [IdW-1:0]      frame_id;
    logic                is_pressed;
    logic [MaxBytes-1:0] byte_en;
    logic [PayloadW-1:0] payload;
  } entry_t;

endpackage

@@ hw/rtl/cbbl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbbl_front
// Classifies an accepted item: tracked byte enables and the press check
// answer against the configured binding.
// ----------------------------------------------------------------------------
module cbbl_front #(
  parameter int unsigned TrackedBytes = 8
) (
  input  logic              accept_i,
  input  cbbl_pkg::item_t   item_i,
  input  cbbl_pkg::bind_t   bind_i,
  output logic              push_o,
  output cbbl_pkg::entry_t  entry_o
);

  logic [7:0] bind_byte_val;
  logic       pressed;

  assign bind_byte_val = item_i.payload[bind_i.byte_sel * 8 +: 8];

  // Byte index must lie below the frame length, not below the tracked length
  assign pressed = bind_i.valid
                && (item_i.frame_id == bind_i.id)
                && ({1'b0, bind_i.byte_sel} < item_i.frame_len)
                && ((bind_byte_val & bind_i.mask) != 8'd0);

  always_comb begin
    entry_o.op         = item_i.operation;
    entry_o.frame_id   = item_i.frame_id;
    entry_o.is_pressed = pressed;
    entry_o.payload    = item_i.payload;
    for (int k = 0; k < int'(cbbl_pkg::MaxBytes); k++) begin
      entry_o.byte_en[k] = (k < int'(TrackedBytes))
                        && (cbbl_pkg::LenW'(k) < item_i.frame_len);
    end
  end

  assign push_o = accept_i;

endmodule

@@ hw/rtl/cbbl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbbl_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module cbbl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cbbl_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output cbbl_pkg::entry_t  entry_o
);

  cbbl_pkg::entry_t                  slots_q [cbbl_pkg::QDepth];
  logic [cbbl_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [cbbl_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [cbbl_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == cbbl_pkg::QCntW'(cbbl_pkg::QDepth));
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == cbbl_pkg::QPtrW'(cbbl_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == cbbl_pkg::QPtrW'(cbbl_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("item pushed into a full queue");

endmodule

@@ hw/rtl/cbbl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbbl_back
// Carries out classified items: scans the id table memory one entry per
// cycle, updates the seen-bit masks, tracks the hunt candidate and forms
// the result.
// ----------------------------------------------------------------------------
module cbbl_back #(
  parameter int unsigned TableEntries = 32,
  parameter int unsigned TrackedBytes = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  cbbl_pkg::entry_t              q_entry_i,
  output logic                          q_pop_o,
  input  logic [cbbl_pkg::HitW-1:0]     confirm_hits_i,
  output logic                          res_valid_o,
  output cbbl_pkg::result_t             res_o
);

  localparam int unsigned CntW  = $clog2(TableEntries + 1);
  localparam int unsigned IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned EverW = 8 * TrackedBytes;
  localparam int unsigned MemW  = cbbl_pkg::IdW + EverW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StExec
  } state_e;

  // Table memory: id in the upper bits, seen-bit mask below
  logic [MemW-1:0]            mem_q [TableEntries];
  logic [MemW-1:0]            rd_q;
  logic [IdxW-1:0]            rd_addr;
  logic                       we;
  logic [IdxW-1:0]            waddr;
  logic [MemW-1:0]            wdata;

  state_e                     state_q, state_d;
  cbbl_pkg::entry_t           cur_q, cur_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [cbbl_pkg::HitW-1:0]  hit_q, hit_d;
  cbbl_pkg::bind_t            cand_q, cand_d;
  cbbl_pkg::bind_t            found_q, found_d;
  logic [CntW-1:0]            addr_q, addr_d;
  logic                       pend_q, pend_d;
  logic [IdxW-1:0]            ridx_q, ridx_d;
  logic                       match_q, match_d;
  logic [IdxW-1:0]            midx_q, midx_d;
  logic [EverW-1:0]           ever_q, ever_d;
  logic                       res_valid_q, res_valid_d;
  cbbl_pkg::result_t          res_q, res_d;

  logic [EverW-1:0]           new_bits;
  logic                       fresh_any;
  logic [cbbl_pkg::ByteIdxW-1:0] sel_byte;
  logic [7:0]                 sel_fresh;
  logic [7:0]                 sel_bit;
  logic                       emit, done, pressed;

  assign rd_addr = addr_q[IdxW-1:0];

  // Tracked payload bytes within the frame length, all others zero
  always_comb begin
    for (int k = 0; k < int'(TrackedBytes); k++) begin
      new_bits[k*8 +: 8] = cur_q.byte_en[k] ? cur_q.payload[k*8 +: 8] : 8'd0;
    end
  end

  // First byte holding unseen bits; walk down so the lowest byte wins
  always_comb begin
    fresh_any = 1'b0;
    sel_byte  = '0;
    sel_fresh = '0;
    for (int k = int'(TrackedBytes) - 1; k >= 0; k--) begin
      if ((new_bits[k*8 +: 8] & ~ever_q[k*8 +: 8]) != 8'd0) begin
        fresh_any = 1'b1;
        sel_byte  = cbbl_pkg::ByteIdxW'(k);
        sel_fresh = new_bits[k*8 +: 8] & ~ever_q[k*8 +: 8];
      end
    end
  end

  assign sel_bit = sel_fresh & (~sel_fresh + 8'd1);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    cand_d      = cand_q;
    found_d     = found_q;
    addr_d      = addr_q;
    pend_d      = 1'b0;
    ridx_d      = ridx_q;
    match_d     = match_q;
    midx_d      = midx_q;
    ever_d      = ever_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    emit        = 1'b0;
    done        = 1'b0;
    pressed     = 1'b0;

    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_entry_i;
          match_d = 1'b0;
          addr_d  = '0;
          case (q_entry_i.op)
            cbbl_pkg::OpClear: begin
              cnt_d   = '0;
              hit_d   = '0;
              cand_d  = '0;
              found_d = '0;
              emit    = 1'b1;
            end
            cbbl_pkg::OpPress: begin
              pressed = q_entry_i.is_pressed;
              emit    = 1'b1;
            end
            cbbl_pkg::OpHunt: begin
              if (found_q.valid) begin
                done = 1'b1;
                emit = 1'b1;
              end else if (cnt_q == '0) begin
                emit = 1'b1;
              end else begin
                state_d = StScan;
              end
            end
            default: begin
              state_d = (cnt_q == '0) ? StExec : StScan;
            end
          endcase
        end
      end

      StScan: begin
        if (pend_q && (rd_q[MemW-1 -: cbbl_pkg::IdW] == cur_q.frame_id)) begin
          match_d = 1'b1;
          midx_d  = ridx_q;
          ever_d  = rd_q[EverW-1:0];
          state_d = StExec;
        end else if (pend_q && ((CntW'(ridx_q) + 1'b1) == cnt_q)) begin
          match_d = 1'b0;
          state_d = StExec;
        end else begin
          // issue the next table read
          pend_d = (addr_q < cnt_q);
          ridx_d = addr_q[IdxW-1:0];
          addr_d = addr_q + 1'b1;
        end
      end

      StExec: begin
        emit    = 1'b1;
        state_d = StIdle;
        if (cur_q.op == cbbl_pkg::OpBaseline) begin
          if (match_q) begin
            we    = 1'b1;
            waddr = midx_q;
            wdata = {cur_q.frame_id, ever_q | new_bits};
          end else if (cnt_q < CntW'(TableEntries)) begin
            we    = 1'b1;
            waddr = cnt_q[IdxW-1:0];
            wdata = {cur_q.frame_id, new_bits};
            cnt_d = cnt_q + 1'b1;
          end
        end else if (match_q && fresh_any) begin
          if (cand_q.valid && (cand_q.id == cur_q.frame_id)
              && (cand_q.byte_sel == sel_byte) && (cand_q.mask == sel_bit)) begin
            hit_d = (hit_q == cbbl_pkg::HitMax) ? hit_q : hit_q + 1'b1;
            if (hit_d >= confirm_hits_i) begin
              found_d = cand_q;
              done    = 1'b1;
            end
          end else begin
            cand_d.valid    = 1'b1;
            cand_d.id       = cur_q.frame_id;
            cand_d.byte_sel = sel_byte;
            cand_d.mask     = sel_bit;
            hit_d           = cbbl_pkg::HitW'(1);
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    if (emit) begin
      res_valid_d         = 1'b1;
      res_d.hunt_done     = done;
      res_d.is_pressed    = pressed;
      res_d.learned_valid = found_d.valid;
      res_d.learned_id    = found_d.id;
      res_d.learned_byte  = found_d.byte_sel;
      res_d.learned_mask  = found_d.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      cnt_q       <= '0;
      hit_q       <= '0;
      cand_q      <= '0;
      found_q     <= '0;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      ridx_q      <= '0;
      match_q     <= 1'b0;
      midx_q      <= '0;
      ever_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      cand_q      <= cand_d;
      found_q     <= found_d;
      addr_q      <= addr_d;
      pend_q      <= pend_d;
      ridx_q      <= ridx_d;
      match_q     <= match_d;
      midx_q      <= midx_d;
      ever_q      <= ever_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_done_learned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.hunt_done) |-> res_q.learned_valid)
    else $error("hunt done without a learned binding");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableEntries))
    else $error("table entry count beyond table size");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (cnt_q != '0))
    else $error("table scan on an empty table");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("two results in consecutive cycles");

endmodule

@@ hw/rtl/can_button_bit_learner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_button_bit_learner
// Learns which CAN frame payload bit a button sets from baseline and hunt
// frames, and checks frames against a configured binding.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low and busy stays
// high until the item's single result has been strobed on result_valid_o
// for one cycle; the receiver cannot stall it, so capture the result then.
// Clear, press check, hunt after a binding is learned and hunt on an empty
// table are answered without a table scan. Baseline and other hunt items
// scan the id table through the single read port of the table memory, one
// entry per cycle, until the id is found or all entries are read (baseline
// on an empty table skips the scan). Configuration must be written through
// cfg_we_i while busy is low; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module can_button_bit_learner #(
  parameter int unsigned TableEntries = 32,
  parameter int unsigned TrackedBytes = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  cbbl_pkg::item_t                item_i,
  output logic                           result_valid_o,
  output cbbl_pkg::result_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [cbbl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cbbl_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic                       busy_q, busy_d;
  logic                       accept;
  logic [cbbl_pkg::HitW-1:0]  confirm_q;
  cbbl_pkg::bind_t            bind_q;

  logic                       push;
  cbbl_pkg::entry_t           push_entry;
  logic                       q_valid, q_full, q_pop;
  cbbl_pkg::entry_t           q_entry;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (result_valid_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      confirm_q <= cbbl_pkg::ConfirmHitsReset;
      bind_q    <= '0;
    end else begin
      busy_q <= busy_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cbbl_pkg::CfgConfirmHits: confirm_q       <= cfg_data_i[7:0];
          cbbl_pkg::CfgBindValid:   bind_q.valid    <= cfg_data_i[0];
          cbbl_pkg::CfgBindId:      bind_q.id       <= cfg_data_i;
          cbbl_pkg::CfgBindByte:    bind_q.byte_sel <= cfg_data_i[2:0];
          cbbl_pkg::CfgBindMask:    bind_q.mask     <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  cbbl_front #(
    .TrackedBytes (TrackedBytes)
  ) u_front (
    .accept_i (accept),
    .item_i   (item_i),
    .bind_i   (bind_q),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  cbbl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .entry_o (q_entry)
  );

  cbbl_back #(
    .TableEntries (TableEntries),
    .TrackedBytes (TrackedBytes)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_entry),
    .q_pop_o        (q_pop),
    .confirm_hits_i (confirm_q),
    .res_valid_o    (result_valid_o),
    .res_o          (result_o)
  );

  a_result_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_q)
    else $error("result without an item in flight");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !q_full)
    else $error("item accepted with the queue full");

endmodule
